>>> sv/otfa_pkg.sv
// Shared types and constants of the owner-tagged frame allocator.
package otfa_pkg;

  localparam int ENTRIES_DEF  = 16384;
  localparam int MAX_DUMP_DEF = 64;

  localparam logic [15:0] KERNEL_TAG = 16'hFFFE;

  // One table word: {loaded, owner, page}.
  localparam int WORD_W = 33;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_DUMP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_NOT_FND  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_SCAN,
    BS_FIN
  } bstate_t;

  // Classified request as it sits in the queue.
  typedef struct packed {
    op_t         op;
    logic [15:0] owner;
    logic [15:0] page;
    logic [13:0] index;
    logic        in_range;
    logic [6:0]  limit;
  } cmd_t;

  // Back end status seen by the front end.
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

>>> sv/owner_tagged_frame_allocator_core.sv
// Top level of the owner-tagged frame allocator.
// The block keeps a table of ENTRIES page frames, each with a page number and an owner
// tag (zero is free, 0xFFFE is the kernel, anything else a process id). A request on the
// slave side carries an opcode in tuser: load writes one entry's page and marks it free,
// allocate hands out the first free frame whose neighbors pass the ownership rule, free
// clears the owner of the first loaded entry holding the page, and dump reports owned
// entries in table order up to a limit (saturated at MAX_DUMP). Load, allocate and free
// answer with one result; dump answers with one result per reported entry, tlast on the
// final one, or a single status-3 result when the limit is zero or nothing is owned.
// After reset the block sweeps the table, one entry per cycle, and holds s_tready low
// until that pass is done. Allocate, free and dump walk the table through its single
// read port, one entry per cycle while the result register is free or being taken,
// ending early once the frame, the page or the dump limit is reached. Backpressure on
// the master side pauses the walk. Up to two requests wait in a queue between the
// front end and the table sequencer, and the result register lets a new request enter
// while the last result still waits to be taken.
module owner_tagged_frame_allocator_core #(
  parameter int ENTRIES  = otfa_pkg::ENTRIES_DEF,
  parameter int MAX_DUMP = otfa_pkg::MAX_DUMP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // owner[15:0], page_number[31:16], entry_index[45:32],
                                 // dump_limit[52:46], zero[55:53]
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_page[15:0], result_owner[31:16]
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast
);
  import otfa_pkg::*;

  logic       q_valid;
  cmd_t       q_cmd;
  back_stat_t bstat;

  otfa_front #(
    .ENTRIES  (ENTRIES),
    .MAX_DUMP (MAX_DUMP)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .bstat    (bstat)
  );

  otfa_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .bstat    (bstat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> sv/otfa_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module otfa_front #(
  parameter int ENTRIES  = 16384,
  parameter int MAX_DUMP = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [55:0]        s_tdata,  // owner, page_number, entry_index, dump_limit, zero pad
  input  logic [1:0]         s_tuser,  // opcode
  output logic               q_valid,
  output otfa_pkg::cmd_t     q_cmd,
  input  otfa_pkg::back_stat_t bstat
);
  import otfa_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  cmd_t       cls;
  logic [6:0] lim_in;
  logic       push;
  logic       pop;

  assign lim_in = s_tdata[52:46];

  // Range check of loads and saturation of the dump limit happen here.
  always_comb begin
    cls.op       = op_t'(s_tuser);
    cls.owner    = s_tdata[15:0];
    cls.page     = s_tdata[31:16];
    cls.index    = s_tdata[45:32];
    cls.in_range = (32'(s_tdata[45:32]) < ENTRIES);
    cls.limit    = (32'(lim_in) > MAX_DUMP) ? 7'(MAX_DUMP) : lim_in;
  end

  assign s_tready = !bstat.clearing && (cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign pop      = bstat.pop && (cnt != 2'd0);
  assign q_valid  = (cnt != 2'd0);
  assign q_cmd    = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

>>> sv/otfa_back.sv
// Back end: frame table memory, scan sequencer and result register.
module otfa_back #(
  parameter int ENTRIES = 16384
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  otfa_pkg::cmd_t       q_cmd,
  output otfa_pkg::back_stat_t bstat,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,  // result_page, result_owner
  output logic [1:0]           m_tuser,  // status
  output logic                 m_tlast
);
  import otfa_pkg::*;

  localparam int AW  = $clog2(ENTRIES);
  localparam int AW1 = $clog2(ENTRIES + 1);

  logic [WORD_W-1:0] mem [ENTRIES];

  bstate_t state, state_next;
  cmd_t    cur;

  logic [AW1-1:0]    ra;
  logic [AW1-1:0]    rd_idx;
  logic [WORD_W-1:0] rd;
  logic              rd_vld;
  logic              rd_virt;
  logic              rd_en;
  logic [WORD_W-1:0] w_prev;
  logic [WORD_W-1:0] w_cur;
  logic [WORD_W-1:0] arr_word;

  logic [6:0]  cnt;
  logic        pend_v;
  logic [15:0] pend_page;
  logic [15:0] pend_owner;
  status_t     fin_status;
  logic [15:0] fin_page;
  logic [15:0] fin_owner;

  logic              en;
  logic              ar;
  logic              we;
  logic [AW-1:0]     wa;
  logic [WORD_W-1:0] wd;
  logic              pop;
  logic              out_load;
  status_t           o_status;
  logic [15:0]       o_page;
  logic [15:0]       o_owner;
  logic              o_last;

  logic [15:0] req;
  logic [15:0] own_l;
  logic [15:0] own_c;
  logic [15:0] own_r;
  logic        ok_l;
  logic        ok_r;
  logic        cand_ok;
  logic        alloc_hit;
  logic        alloc_end;
  logic        free_hit;
  logic        free_end;
  logic        dump_own;
  logic        dump_full;
  logic        dump_end;

  assign en       = !m_tvalid || m_tready;
  assign ar       = (state == BS_SCAN) && en && rd_vld;
  assign arr_word = rd_virt ? '0 : rd;
  assign rd_en    = (state == BS_SCAN) && en && (ra < AW1'(ENTRIES));

  // Candidate is the entry before the one that just arrived; that one is its right side.
  assign req   = cur.owner;
  assign own_l = w_prev[31:16];
  assign own_c = w_cur[31:16];
  assign own_r = arr_word[31:16];
  assign ok_l  = (own_l == 16'd0) || (own_l == KERNEL_TAG) || (own_l == req);
  assign ok_r  = (own_r == 16'd0) || (own_r == KERNEL_TAG) || (own_r == req);

  always_comb begin
    cand_ok = 1'b0;
    if ((rd_idx != '0) && (own_c == 16'd0)) begin
      if (rd_idx == AW1'(1)) begin
        cand_ok = (own_r == 16'd0) || (own_r == req);
      end else begin
        cand_ok = (req == KERNEL_TAG) || (ok_l && ok_r);
      end
    end
  end

  assign alloc_hit = ar && (cur.op == OP_ALLOC) && cand_ok;
  assign alloc_end = ar && (cur.op == OP_ALLOC) && rd_virt && !cand_ok;
  assign free_hit  = ar && (cur.op == OP_FREE) && !rd_virt && rd[32] && (rd[15:0] == cur.page);
  assign free_end  = ar && (cur.op == OP_FREE) && rd_virt;
  assign dump_own  = ar && (cur.op == OP_DUMP) && !rd_virt && (rd[31:16] != 16'd0);
  assign dump_full = dump_own && (7'(cnt + 7'd1) == cur.limit);
  assign dump_end  = ar && (cur.op == OP_DUMP) && rd_virt;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BS_CLEAR: begin
        if (ra == AW1'(ENTRIES - 1)) begin
          state_next = BS_IDLE;
        end
      end
      BS_IDLE: begin
        if (q_valid) begin
          if ((q_cmd.op == OP_LOAD) || ((q_cmd.op == OP_DUMP) && (q_cmd.limit == 7'd0))) begin
            state_next = BS_FIN;
          end else begin
            state_next = BS_SCAN;
          end
        end
      end
      BS_SCAN: begin
        if (alloc_hit || alloc_end || free_hit || free_end || dump_full || dump_end) begin
          state_next = BS_FIN;
        end
      end
      BS_FIN: begin
        if (en) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  // Outputs of the sequencer: table writes, queue pop and result loads.
  always_comb begin
    we       = 1'b0;
    wa       = '0;
    wd       = '0;
    pop      = 1'b0;
    out_load = 1'b0;
    o_status = ST_OK;
    o_page   = 16'd0;
    o_owner  = 16'd0;
    o_last   = 1'b0;
    case (state)
      BS_CLEAR: begin
        we = 1'b1;
        wa = ra[AW-1:0];
      end
      BS_IDLE: begin
        pop = q_valid;
        if (q_valid && (q_cmd.op == OP_LOAD) && q_cmd.in_range) begin
          we = 1'b1;
          wa = AW'(32'(q_cmd.index));
          wd = {1'b1, 16'd0, q_cmd.page};
        end
      end
      BS_SCAN: begin
        if (alloc_hit) begin
          we = 1'b1;
          wa = AW'(rd_idx - AW1'(1));
          wd = {w_cur[32], req, w_cur[15:0]};
        end else if (free_hit) begin
          we = 1'b1;
          wa = rd_idx[AW-1:0];
          wd = {1'b1, 16'd0, rd[15:0]};
        end
        if (dump_own && pend_v) begin
          out_load = 1'b1;
          o_page   = pend_page;
          o_owner  = pend_owner;
        end
      end
      BS_FIN: begin
        if (en) begin
          out_load = 1'b1;
          o_status = fin_status;
          o_page   = fin_page;
          o_owner  = fin_owner;
          o_last   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign bstat = '{clearing: (state == BS_CLEAR), pop: pop};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd <= mem[ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BS_CLEAR;
      ra       <= '0;
      rd_vld   <= 1'b0;
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tuser  <= o_status;
        m_tdata  <= {o_owner, o_page};
        m_tlast  <= o_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        BS_CLEAR: begin
          ra <= AW1'(ra + AW1'(1));
        end
        BS_IDLE: begin
          if (q_valid) begin
            cur        <= q_cmd;
            ra         <= '0;
            rd_vld     <= 1'b0;
            cnt        <= 7'd0;
            pend_v     <= 1'b0;
            fin_status <= (q_cmd.op == OP_DUMP) ? ST_EMPTY : ST_OK;
            fin_page   <= 16'd0;
            fin_owner  <= 16'd0;
          end
        end
        BS_SCAN: begin
          if (en) begin
            if (ra <= AW1'(ENTRIES)) begin
              rd_vld  <= 1'b1;
              rd_idx  <= ra;
              rd_virt <= (ra == AW1'(ENTRIES));
              ra      <= AW1'(ra + AW1'(1));
            end else begin
              rd_vld <= 1'b0;
            end
          end
          if (ar) begin
            w_prev <= w_cur;
            w_cur  <= arr_word;
          end
          if (alloc_hit) begin
            fin_status <= ST_OK;
            fin_page   <= w_cur[15:0];
            fin_owner  <= 16'd0;
          end
          if (alloc_end) begin
            fin_status <= ST_NO_FRAME;
            fin_page   <= 16'd0;
            fin_owner  <= 16'd0;
          end
          if (free_hit) begin
            fin_status <= ST_OK;
          end
          if (free_end) begin
            fin_status <= ST_NOT_FND;
          end
          if (dump_own) begin
            pend_v     <= 1'b1;
            pend_page  <= rd[15:0];
            pend_owner <= rd[31:16];
            cnt        <= 7'(cnt + 7'd1);
            if (dump_full) begin
              fin_status <= ST_OK;
              fin_page   <= rd[15:0];
              fin_owner  <= rd[31:16];
            end
          end
          if (dump_end) begin
            fin_status <= pend_v ? ST_OK : ST_EMPTY;
            fin_page   <= pend_v ? pend_page : 16'd0;
            fin_owner  <= pend_v ? pend_owner : 16'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // No request leaves the queue while the table is still being cleared.
  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst)
    (state == BS_CLEAR) |-> !pop) else $error("request popped during clear");

  // A table write during a scan always ends that scan.
  a_write_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (we && (state == BS_SCAN)) |=> (state == BS_FIN)) else $error("scan kept going after write");

  // A dump never counts more reports than its limit.
  a_dump_limit: assert property (@(posedge clk) disable iff (rst)
    ((state == BS_SCAN) && (cur.op == OP_DUMP)) |-> (cnt <= cur.limit))
    else $error("dump count beyond limit");

  // The sequencer only loads the result register when it is free or being taken.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> en) else $error("result register overwritten");

endmodule

>>> dv/owner_tagged_frame_allocator_core_tb.sv
// Self-checking testbench for the owner-tagged frame allocator core.
module owner_tagged_frame_allocator_core_tb;
  import otfa_pkg::*;

  localparam int NENT = ENTRIES_DEF;
  localparam int DUMP_MAX = MAX_DUMP_DEF;

  typedef struct packed {
    op_t         op;
    logic [15:0] owner;
    logic [15:0] page;
    logic [13:0] index;
    logic [6:0]  limit;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] page;
    logic [15:0] owner;
    logic        last;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  owner_tagged_frame_allocator_core dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  logic [15:0] frame_page [NENT];
  logic [15:0] frame_owner [NENT];
  bit          frame_loaded [NENT];

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int answers_seen = 0;
  int requests_sent = 0;
  int phase = 0;          // 0: sender idles less, 1: receiver idles less, 2: none
  bit stall_long = 1'b0;
  int loaded_count = 0;   // entries 0..loaded_count-1 have been loaded

  function automatic bit neighbor_fits(logic [15:0] tag, logic [15:0] req);
    return tag == 16'd0 || tag == KERNEL_TAG || tag == req;
  endfunction

  // Entry an allocation by this requester would take now, or -1 when none fits.
  function automatic int alloc_target(logic [15:0] req);
    logic [15:0] right;
    if (frame_owner[0] == 16'd0 && (frame_owner[1] == 16'd0 || frame_owner[1] == req))
      return 0;
    for (int i = 1; i < NENT; i++) begin
      if (frame_owner[i] != 16'd0) continue;
      if (req == KERNEL_TAG) return i;
      right = (i + 1 < NENT) ? frame_owner[i + 1] : 16'd0;
      if (neighbor_fits(frame_owner[i - 1], req) && neighbor_fits(right, req)) return i;
    end
    return -1;
  endfunction

  // Computes the answers of one request and updates the predicted table.
  task automatic predict_request(request_t r);
    answer_t a;
    int found;
    int count;
    int lim;
    a = '{ST_OK, 16'd0, 16'd0, 1'b1};
    case (r.op)
      OP_LOAD: begin
        frame_page[r.index] = r.page;
        frame_owner[r.index] = 16'd0;
        frame_loaded[r.index] = 1'b1;
        expected_answers.push_back(a);
      end
      OP_ALLOC: begin
        found = alloc_target(r.owner);
        if (found >= 0) begin
          frame_owner[found] = r.owner;
          a.page = frame_page[found];
        end else a.status = ST_NO_FRAME;
        expected_answers.push_back(a);
      end
      OP_FREE: begin
        a.status = ST_NOT_FND;
        for (int i = 0; i < NENT; i++) begin
          if (frame_loaded[i] && frame_page[i] == r.page) begin
            frame_owner[i] = 16'd0;
            a.status = ST_OK;
            break;
          end
        end
        expected_answers.push_back(a);
      end
      default: begin
        count = 0;
        lim = (r.limit > DUMP_MAX) ? DUMP_MAX : r.limit;
        if (lim != 0) begin
          for (int i = 0; i < NENT && count < lim; i++) begin
            if (frame_owner[i] != 0) begin
              a = '{ST_OK, frame_page[i], frame_owner[i], 1'b0};
              expected_answers.push_back(a);
              count++;
            end
          end
        end
        if (count == 0) expected_answers.push_back('{ST_EMPTY, 16'd0, 16'd0, 1'b1});
        else expected_answers[$].last = 1'b1;
      end
    endcase
  endtask

  // Driver: offers the head of the queue; predicts when the request is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_request(pending_requests.pop_front());
        requests_sent++;
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (pending_requests.size() > 0 && !(phase == 0 && $urandom_range(99) < 19)
                   && !(phase == 1 && $urandom_range(99) < 55)) begin
        request_t r;
        r = pending_requests[0];
        s_tdata <= {3'd0, r.limit, r.index, r.page, r.owner};
        s_tuser <= r.op;
        s_tvalid <= 1'b1;
      end else s_tvalid <= 1'b0;
    end
  end

  // Monitor: checks each answer against the oldest expectation.
  always @(posedge clk) begin
    answer_t exp_a;
    answer_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{status_t'(m_tuser), m_tdata[15:0], m_tdata[31:16], m_tlast};
        answers_seen++;
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected answer %h", $time, got);
          errors++;
        end else begin
          exp_a = expected_answers.pop_front();
          if (exp_a != got) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_a, got);
            errors++;
          end
        end
      end
      m_tready <= stall_long ? 1'b0 :
                  (phase == 0) ? ($urandom_range(99) >= 55) :
                  (phase == 1) ? ($urandom_range(99) >= 19) : 1'b1;
    end
  end

  function automatic request_t make_req(op_t op, logic [15:0] owner, logic [15:0] page,
                                        logic [13:0] index, logic [6:0] limit);
    return '{op, owner, page, index, limit};
  endfunction

  // Picks a page that is loaded, or sometimes any page.
  function automatic logic [15:0] pick_page();
    if (loaded_count > 0 && $urandom_range(3) != 0)
      return frame_page[$urandom_range(loaded_count - 1)];
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_owner();
    case ($urandom_range(5))
      0: return KERNEL_TAG;
      1: return 16'd0;
      2: return 16'h7FFF;
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic wait_drain();
    while (pending_requests.size() != 0 || s_tvalid || expected_answers.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    request_t r;
    int tgt;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // Directed part. Loads write distinct pages so free finds a single match;
    // entries at the top end are loaded only as distinct pages too.
    pending_requests.push_back(make_req(OP_DUMP, 16'd1, 16'd0, 14'd0, 7'd5));     // empty dump
    pending_requests.push_back(make_req(OP_DUMP, 16'd1, 16'd0, 14'd0, 7'd0));     // limit zero
    pending_requests.push_back(make_req(OP_FREE, 16'd0, 16'hFFFF, 14'd0, 7'd1));  // not found
    for (int i = 0; i < 8; i++)
      pending_requests.push_back(make_req(OP_LOAD, 16'hFFFF, 16'(16'hA000 + i), 14'(i), 7'h7F));
    loaded_count = 8;
    pending_requests.push_back(make_req(OP_LOAD, 16'd0, 16'hFFFF, 14'h3FFF, 7'd0));
    pending_requests.push_back(make_req(OP_ALLOC, 16'd3, 16'd0, 14'd0, 7'd0));
    pending_requests.push_back(make_req(OP_ALLOC, KERNEL_TAG, 16'd0, 14'd0, 7'd0));
    pending_requests.push_back(make_req(OP_ALLOC, 16'd4, 16'd0, 14'd0, 7'd0));
    pending_requests.push_back(make_req(OP_ALLOC, 16'h7FFF, 16'd0, 14'd0, 7'd0));
    pending_requests.push_back(make_req(OP_ALLOC, 16'd0, 16'd0, 14'd0, 7'd0));    // requester zero
    pending_requests.push_back(make_req(OP_DUMP, 16'd0, 16'd0, 14'd0, 7'h7F));    // saturating limit
    pending_requests.push_back(make_req(OP_DUMP, 16'd0, 16'd0, 14'd0, 7'd1));
    pending_requests.push_back(make_req(OP_FREE, 16'd0, 16'hA001, 14'd0, 7'd0));
    pending_requests.push_back(make_req(OP_FREE, 16'd0, 16'hA001, 14'd0, 7'd0));
    wait_drain();

    // Random part: mostly allocate, free and dump on a small loaded region,
    // with further loads growing it. Each allocation is checked against the
    // predicted table first so that it never lands on an entry that was never loaded.
    for (int n = 0; n < 300; n++) begin
      if (n == 100) begin
        wait_drain();
        phase = 1;
      end
      if (n == 200) begin
        wait_drain();
        phase = 2;
      end
      case ($urandom_range(9))
        0, 1: begin
          if (loaded_count < 64) begin
            r = make_req(OP_LOAD, 16'($urandom), 16'(16'hA000 + loaded_count),
                         14'(loaded_count), 7'($urandom));
            loaded_count++;
          end else
            r = make_req(OP_LOAD, 16'($urandom), 16'(16'h5000 + $urandom_range(4095)),
                         14'($urandom_range(16383 - 4095, 16383)), 7'($urandom));
        end
        2, 3, 4: begin
          wait_drain();
          r = make_req(OP_ALLOC, pick_owner(), 16'($urandom), 14'($urandom), 7'($urandom));
          tgt = alloc_target(r.owner);
          if (tgt >= 0 && !frame_loaded[tgt]) begin
            r.owner = KERNEL_TAG;
            tgt = alloc_target(r.owner);
            if (tgt >= 0 && !frame_loaded[tgt])
              r = make_req(OP_DUMP, 16'd0, 16'd0, 14'd0, 7'd0);
          end
        end
        5, 6, 7: r = make_req(OP_FREE, 16'($urandom), pick_page(), 14'($urandom), 7'($urandom));
        default: r = make_req(OP_DUMP, 16'($urandom), 16'($urandom), 14'($urandom),
                              7'($urandom_range(0, 127)));
      endcase
      pending_requests.push_back(r);
      // Keep the owned count below the loaded region to avoid reading unloaded pages.
      if (r.op == OP_ALLOC) begin
        wait_drain();
        if (loaded_count < 64 && expected_answers.size() == 0) begin
          int owned;
          owned = 0;
          for (int i = 0; i < 64; i++) if (frame_owner[i] != 0) owned++;
          while (owned + 4 > loaded_count && loaded_count < 64) begin
            pending_requests.push_back(make_req(OP_LOAD, 16'd0, 16'(16'hA000 + loaded_count),
                                                14'(loaded_count), 7'd0));
            loaded_count++;
          end
        end
        if (loaded_count >= 64) begin
          int owned;
          owned = 0;
          for (int i = 0; i < 64; i++) if (frame_owner[i] != 0) owned++;
          if (owned > 48)
            for (int i = 0; i < 64; i++)
              if (frame_owner[i] != 0 && $urandom_range(1))
                pending_requests.push_back(make_req(OP_FREE, 16'd0, frame_page[i], 14'd0, 7'd0));
        end
      end
      if (n == 250) begin
        // Long receiver stall while dumps keep coming, filling the block.
        stall_long = 1'b1;
        for (int k = 0; k < 4; k++)
          pending_requests.push_back(make_req(OP_DUMP, 16'd0, 16'd0, 14'd0, 7'd64));
        repeat (400) @(posedge clk);
        stall_long = 1'b0;
      end
    end
    wait_drain();
    repeat (NENT + 50) @(posedge clk);
    $display("Covered %0d requests and %0d answers: loads, allocations by kernel,", requests_sent,
             answers_seen);
    $display("process and zero owners, frees found and missing, dumps empty and saturated.");
    if (errors == 0 && expected_answers.size() == 0)
      $display("owner_tagged_frame_allocator_core verification clean");
    else
      $display("owner_tagged_frame_allocator_core verification failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < NENT; i++) begin
      frame_page[i] = 16'd0;
      frame_owner[i] = 16'd0;
      frame_loaded[i] = 1'b0;
    end
    #(10 * 40_000_000);
    $display("owner_tagged_frame_allocator_core verification failed");
    $finish;
  end

endmodule

>>> owner_tagged_frame_allocator_core.f
sv/otfa_pkg.sv
sv/otfa_front.sv
sv/otfa_back.sv
sv/owner_tagged_frame_allocator_core.sv
dv/owner_tagged_frame_allocator_core_tb.sv
